@@ src/lbu8_pkg.sv @@
package lbu8_pkg;

	localparam logic [1:0] CLASS_ORDINARY = 2'd0;
	localparam logic [1:0] CLASS_MONO     = 2'd1;
	localparam logic [1:0] CLASS_SYMBOL   = 2'd2;

	localparam int unsigned MAX_WORDS = 6;
	localparam int unsigned IDX_W     = $clog2(MAX_WORDS);

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] code_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam byte_t SPACE_CHAR = 8'h20;
	localparam byte_t LEAD2      = 8'hC0;
	localparam byte_t LEAD3      = 8'hE0;
	localparam byte_t CONT       = 8'h80;
	localparam code_t TWO_BYTE_LIMIT = 16'h0800;

	localparam byte_t NBSP_TEXT [MAX_WORDS] = '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B};

	function automatic code_t lookup_code(input byte_t b, input logic [1:0] cls);
		code_t code;
		code = '0;
		if (cls == CLASS_SYMBOL) begin
			unique case (b)
				8'd180:  code = 16'h00D7;
				8'd210:  code = 16'h00AE;
				8'd211:  code = 16'h00A9;
				8'd212:  code = 16'h2122;
				default: code = '0;
			endcase
		end else begin
			unique case (b)
				8'h86:   code = 16'h2020;
				8'h87:   code = 16'h2021;
				8'h93:   code = 16'h201C;
				8'h94:   code = 16'h201D;
				8'h96:   code = 16'h2013;
				8'h97:   code = 16'h2014;
				8'hA0:   code = 16'h00A0;
				8'hA9:   code = 16'h00A9;
				8'hB7:   code = 16'h00B7;
				default: code = '0;
			endcase
		end
		return code;
	endfunction

endpackage

@@ src/legacy_byte_to_utf8_transcoder.sv @@
// The first output word appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle while each expands to a single output word and out_ready stays high.
// A word that expands to n output words occupies the single result buffer until its last output word is taken.
// A high byte with no mapping produces nothing and leaves the result buffer empty.
// Reset (arst_n low, asynchronous) empties the result buffer and sets font_class to 0.
module legacy_byte_to_utf8_transcoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ansi_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	logic [1:0]         font_class_q;
	lbu8_pkg::byte_t    buf_q [lbu8_pkg::MAX_WORDS];
	lbu8_pkg::idx_t     idx_q;
	lbu8_pkg::idx_t     last_idx_q;
	logic               busy_q;

	lbu8_pkg::byte_t    nbuf [lbu8_pkg::MAX_WORDS];
	lbu8_pkg::idx_t     nlast;
	logic               nload;
	lbu8_pkg::code_t    code;
	logic               in_acc;
	logic               out_acc;
	logic               out_done;

	assign out_valid = busy_q;
	assign out_byte  = buf_q[idx_q];
	assign last_byte = (idx_q == last_idx_q);
	assign out_acc   = out_valid && out_ready;
	assign out_done  = out_acc && last_byte;
	assign in_ready  = !busy_q || out_done;
	assign in_acc    = in_valid && in_ready;

	assign code = lbu8_pkg::lookup_code(ansi_byte, font_class_q);

	always_comb begin
		for (int i = 0; i < lbu8_pkg::MAX_WORDS; i++) begin
			nbuf[i] = lbu8_pkg::NBSP_TEXT[i];
		end
		nlast = '0;
		nload = 1'b0;
		priority if (ansi_byte == lbu8_pkg::SPACE_CHAR &&
				font_class_q == lbu8_pkg::CLASS_MONO) begin
			nlast = lbu8_pkg::idx_t'(lbu8_pkg::MAX_WORDS - 1);
			nload = 1'b1;
		end else if (!ansi_byte[7]) begin
			nbuf[0] = ansi_byte;
			nload   = 1'b1;
		end else if (code == '0) begin
			nload = 1'b0;
		end else if (code < lbu8_pkg::TWO_BYTE_LIMIT) begin
			nbuf[0] = lbu8_pkg::LEAD2 | {3'b000, code[10:6]};
			nbuf[1] = lbu8_pkg::CONT | {2'b00, code[5:0]};
			nlast   = lbu8_pkg::idx_t'(1);
			nload   = 1'b1;
		end else begin
			nbuf[0] = lbu8_pkg::LEAD3 | {4'b0000, code[15:12]};
			nbuf[1] = lbu8_pkg::CONT | {2'b00, code[11:6]};
			nbuf[2] = lbu8_pkg::CONT | {2'b00, code[5:0]};
			nlast   = lbu8_pkg::idx_t'(2);
			nload   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_class_q <= lbu8_pkg::CLASS_ORDINARY;
		end else if (cfg_we) begin
			font_class_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_acc) begin
			busy_q <= nload;
			idx_q  <= '0;
		end else if (out_done) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (out_acc) begin
			idx_q <= idx_q + lbu8_pkg::idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && nload) begin
			buf_q      <= nbuf;
			last_idx_q <= nlast;
		end
	end

endmodule

@@ src/lbu8_checker.sv @@
module lbu8_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] ansi_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_byte
);

	// A stalled output word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
		else $error("output word changed while stalled");

	// The input side only waits while a result is pending.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending output");

	// A word that is not the last of its group is followed by more.
	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=> out_valid)
		else $error("output group ended early");

	// A plain ASCII word other than space comes out next cycle unchanged and alone.
	a_ascii_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !ansi_byte[7] && ansi_byte != 8'h20
		|=> out_valid && last_byte && out_byte == $past(ansi_byte))
		else $error("ASCII word not passed through");

endmodule

bind legacy_byte_to_utf8_transcoder lbu8_checker u_lbu8_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.ansi_byte (ansi_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last_byte (last_byte)
);
